// File: sv/lars_pkg.sv
// Shared types and constants for the raster life step block.
// Register indexes, reset values of the rule masks, result word layout.
// No dependencies.
package lars_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd1;
  localparam cfg_idx_t REG_BIRTH_MASK   = 2'd2;
  localparam cfg_idx_t REG_SURVIVE_MASK = 2'd3;

  // Register widths and reset values (birth on 3, survive on 2 or 3)
  localparam int CFG_DATA_W = 9;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_data_t RST_FRAME_WIDTH  = 9'd256;
  localparam cfg_data_t RST_FRAME_HEIGHT = 9'd256;
  localparam cfg_data_t RST_BIRTH_MASK   = 9'b000001000;
  localparam cfg_data_t RST_SURVIVE_MASK = 9'b000001100;
  localparam cfg_data_t MIN_FRAME_SIZE   = 9'd3;

  // Position fields of a result word
  localparam int POS_W = 8;
  typedef logic [POS_W-1:0] pos_t;

  // Live neighbour count, 0..8
  typedef logic [3:0] nbr_count_t;

  typedef struct packed {
    logic alive;
    pos_t row;
    pos_t col;
    logic last;
  } res_t;

  // Count live neighbours: the eight window bits around the centre
  function automatic nbr_count_t count_neighbours(input logic [8:0] win);
    nbr_count_t n;
    n = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        n = n + nbr_count_t'(win[k]);
      end
    end
    return n;
  endfunction

endpackage

// File: sv/life_automaton_raster_step.sv
// One generation step of a B3/S23-style life grid, streamed in raster order.
// Depends on lars_pkg (register indexes, result word, neighbour count).

// The block takes one cell per cycle in raster order while in_stall is low, and returns
// through its output register the next state of the cell one row up and one column left,
// with its row and column; inputs in row 0 or column 0 give no word. Border cells come
// out dead, and frame_last marks the word from the final input of a frame. Two line
// stores keep the two rows above; each is read ahead, into a registered read word, at the
// column that the next cell will use, so a cell can enter every cycle that in_stall is low.
// The result sits in an output register backed by one skid word: in_stall rises only while
// the skid word is held. The user must write frame size and rule masks through the
// configuration port only while the stream is idle; the block does not enforce it. Sizes
// outside 3..MAX saturate. The stores need no clearing after reset.
module life_automaton_raster_step #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  // cell input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cell_alive,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 next_alive,
  output lars_pkg::pos_t       out_row,
  output lars_pkg::pos_t       out_col,
  output logic                 frame_last,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  lars_pkg::cfg_idx_t   cfg_index,
  input  lars_pkg::cfg_data_t  cfg_data
);
  import lars_pkg::*;

  localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  typedef logic [CW-1:0] col_t;
  typedef logic [RW-1:0] row_t;
  typedef logic [CW:0]   wsize_t;
  typedef logic [RW:0]   hsize_t;

  // Configuration registers
  cfg_data_t frame_width;
  cfg_data_t frame_height;
  cfg_data_t birth_mask;
  cfg_data_t survive_mask;

  // Stream state
  col_t       col_counter;
  col_t       col_counter_next;
  row_t       row_counter;
  row_t       row_counter_next;
  logic [8:0] window_bits;
  logic [8:0] window_bits_next;

  // Line stores and their registered read words
  logic line_store_above     [MAX_WIDTH];
  logic line_store_two_above [MAX_WIDTH];
  logic above_rd;
  logic two_above_rd;
  col_t rd_addr;

  // Output register and skid word
  res_t res_out;
  res_t res_skid;
  logic skid_valid;
  res_t res_new;

  logic   in_take;
  logic   out_take;
  logic   emit;
  wsize_t w_size;
  hsize_t h_size;
  wsize_t col_inc;
  hsize_t row_inc;
  hsize_t row_adv;
  row_t   row_m1;
  col_t   col_m1;
  logic   centre;
  nbr_count_t nbr;
  logic   next_state;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_take   = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      birth_mask   <= RST_BIRTH_MASK;
      survive_mask <= RST_SURVIVE_MASK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_BIRTH_MASK:   birth_mask   <= cfg_data;
        REG_SURVIVE_MASK: survive_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate frame size to 3..MAX
  always_comb begin
    if (frame_width < MIN_FRAME_SIZE) begin
      w_size = wsize_t'(MIN_FRAME_SIZE);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_size = wsize_t'(MAX_WIDTH);
    end else begin
      w_size = wsize_t'(frame_width);
    end
    if (frame_height < MIN_FRAME_SIZE) begin
      h_size = hsize_t'(MIN_FRAME_SIZE);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_size = hsize_t'(MAX_HEIGHT);
    end else begin
      h_size = hsize_t'(frame_height);
    end
  end

  // Advance raster position; wrap at once if past the current size
  always_comb begin
    col_inc = wsize_t'(col_counter) + 1'b1;
    row_adv = hsize_t'(row_counter);
    col_counter_next = col_counter;
    row_counter_next = row_counter;
    row_inc = row_adv;
    if (in_take) begin
      if (col_inc >= w_size) begin
        col_counter_next = '0;
        row_inc = row_adv + 1'b1;
      end else begin
        col_counter_next = col_inc[CW-1:0];
      end
      if (row_inc >= h_size) begin
        row_counter_next = '0;
      end else begin
        row_counter_next = row_inc[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_counter <= '0;
      row_counter <= '0;
      window_bits <= '0;
    end else begin
      col_counter <= col_counter_next;
      row_counter <= row_counter_next;
      if (in_take) begin
        window_bits <= window_bits_next;
      end
    end
  end

  // Shift the new column into the window: two-up, one-up, current
  assign window_bits_next = {cell_alive, above_rd, two_above_rd, window_bits[8:3]};

  // Read the next column into the registered read words; write the current column
  assign rd_addr = rst ? '0 : col_counter_next;

  always_ff @(posedge clk) begin
    if (in_take) begin
      line_store_two_above[col_counter] <= above_rd;
      line_store_above[col_counter]     <= cell_alive;
    end
    above_rd     <= line_store_above[rd_addr];
    two_above_rd <= line_store_two_above[rd_addr];
  end

  // Apply the rule to the window centre
  always_comb begin
    row_m1 = row_counter - 1'b1;
    col_m1 = col_counter - 1'b1;
    emit   = (row_counter != '0) && (col_counter != '0)
          && (hsize_t'(row_counter) < h_size) && (wsize_t'(col_counter) < w_size);
    centre = window_bits_next[4];
    nbr    = count_neighbours(window_bits_next);
    if (row_m1 == '0 || col_m1 == '0) begin
      next_state = 1'b0;
    end else if (centre) begin
      next_state = survive_mask[nbr];
    end else begin
      next_state = birth_mask[nbr];
    end
    res_new.alive = next_state;
    res_new.row   = pos_t'(row_m1);
    res_new.col   = pos_t'(col_m1);
    res_new.last  = (hsize_t'(row_counter) == h_size - 1'b1)
                 && (wsize_t'(col_counter) == w_size - 1'b1);
  end

  // Output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (in_take && emit) begin
      if (out_valid && !out_take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        res_out <= res_skid;
      end
    end else if (in_take && emit) begin
      if (out_valid && !out_take) begin
        res_skid <= res_new;
      end else begin
        res_out <= res_new;
      end
    end
  end

  assign next_alive = res_out.alive;
  assign out_row    = res_out.row;
  assign out_col    = res_out.col;
  assign frame_last = res_out.last;

endmodule

// File: tb/tb_life_automaton_raster_step.sv
// Testbench for life_automaton_raster_step: streams cell grids with random gaps and
// output stalls, and checks every result word against a next-generation predictor.
// Depends on lars_pkg and the life_automaton_raster_step block.
module tb_life_automaton_raster_step;
  timeunit 1ns;
  timeprecision 1ps;
  import lars_pkg::*;

  localparam int GRID_MAX = 256;

  // Predicts the next generation from the accepted cell stream
  class next_gen_tracker;
    cfg_data_t width_reg;
    cfg_data_t height_reg;
    cfg_data_t birth_reg;
    cfg_data_t survive_reg;
    logic above [GRID_MAX];
    logic two_above [GRID_MAX];
    logic [8:0] win;
    int unsigned row_ctr;
    int unsigned col_ctr;
    res_t due_cells [$];
    int mismatches;

    function new();
      width_reg = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      birth_reg = RST_BIRTH_MASK;
      survive_reg = RST_SURVIVE_MASK;
      foreach (above[i]) begin
        above[i] = 1'b0;
        two_above[i] = 1'b0;
      end
      win = '0;
      row_ctr = 0;
      col_ctr = 0;
      mismatches = 0;
    endfunction

    function int unsigned fit_size(cfg_data_t v);
      if (v < MIN_FRAME_SIZE) return MIN_FRAME_SIZE;
      if (v > GRID_MAX) return GRID_MAX;
      return v;
    endfunction

    function void set_reg(cfg_idx_t idx, cfg_data_t val);
      case (idx)
        REG_FRAME_WIDTH: width_reg = val;
        REG_FRAME_HEIGHT: height_reg = val;
        REG_BIRTH_MASK: birth_reg = val;
        REG_SURVIVE_MASK: survive_reg = val;
        default: ;
      endcase
    endfunction

    // Shift the window, update the line stores and queue the emitted cell
    function void take_cell(logic v);
      int unsigned w;
      int unsigned h;
      logic [7:0] slot;
      nbr_count_t n;
      res_t e;
      w = fit_size(width_reg);
      h = fit_size(height_reg);
      slot = col_ctr[7:0];
      win = {v, above[slot], two_above[slot], win[8:3]};
      two_above[slot] = above[slot];
      above[slot] = v;
      if (row_ctr >= 1 && col_ctr >= 1 && row_ctr < h && col_ctr < w) begin
        n = '0;
        for (int k = 0; k < 9; k++) begin
          if (k != 4) n += nbr_count_t'(win[k]);
        end
        // border cells always come out dead
        if (row_ctr == 1 || col_ctr == 1) e.alive = 1'b0;
        else if (win[4]) e.alive = survive_reg[n];
        else e.alive = birth_reg[n];
        e.row = pos_t'(row_ctr - 1);
        e.col = pos_t'(col_ctr - 1);
        e.last = (row_ctr == h - 1 && col_ctr == w - 1);
        due_cells.push_back(e);
      end
      // advance the raster position, wrapping at once past the frame size
      col_ctr++;
      if (col_ctr >= w) begin
        col_ctr = 0;
        row_ctr++;
      end
      if (row_ctr >= h) row_ctr = 0;
    endfunction

    function void note_fault(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void match_word(res_t got);
      res_t e;
      if (due_cells.size() == 0) begin
        note_fault($sformatf("unexpected word alive=%0b row=%0d col=%0d last=%0b",
                             got.alive, got.row, got.col, got.last));
        return;
      end
      e = due_cells.pop_front();
      if (got.alive !== e.alive || got.row !== e.row || got.col !== e.col ||
          got.last !== e.last)
        note_fault($sformatf("expected alive=%0b row=%0d col=%0d last=%0b, got %0b %0d %0d %0b",
                             e.alive, e.row, e.col, e.last,
                             got.alive, got.row, got.col, got.last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic cell_alive;
  logic out_valid;
  logic out_stall;
  logic next_alive;
  pos_t out_row;
  pos_t out_col;
  logic frame_last;
  logic cfg_valid;
  logic cfg_ready;
  cfg_idx_t cfg_index;
  cfg_data_t cfg_data;

  next_gen_tracker board = new();
  bit quiet = 1'b0;
  int cells_sent = 0;
  int stall_left = 0;
  int free_left = 0;

  life_automaton_raster_step uut (.*);

  always #6 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Check each result word taken by the receiver
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.match_word({next_alive, out_row, out_col, frame_last});
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (quiet || free_left > 0) begin
      out_stall <= 1'b0;
      if (free_left > 0) free_left--;
    end else begin
      free_left = $urandom_range(0, 5);
      stall_left = gap_len();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Send one cell word; entered and left at a falling edge
  task automatic send_cell(input logic v);
    int g;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    cell_alive <= v;
    do @(posedge clk); while (in_stall);
    board.take_cell(v);
    cells_sent++;
    @(negedge clk);
  endtask

  task automatic run_cells(input int count, input int density);
    for (int i = 0; i < count; i++) send_cell($urandom_range(0, 7) < density);
  endtask

  // Send a 3x3 frame, top row in the upper bits
  task automatic send_frame9(input logic [8:0] cells);
    for (int i = 8; i >= 0; i--) send_cell(cells[i]);
  endtask

  // Drop valid and hold until every word is back and the pipeline has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.due_cells.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int pick;
    cfg_data_t val;
    rst = 1'b1;
    in_valid = 1'b0;
    cell_alive = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: undersized frame saturates to 3x3, only the centre is inner
    write_reg(REG_FRAME_WIDTH, 9'd0);
    write_reg(REG_FRAME_HEIGHT, 9'd2);
    write_reg(REG_BIRTH_MASK, RST_BIRTH_MASK);
    write_reg(REG_SURVIVE_MASK, RST_SURVIVE_MASK);
    send_frame9(9'b010_010_010);
    send_frame9(9'b111_111_111);
    send_frame9(9'b101_101_101);
    wait_idle();
    write_reg(REG_BIRTH_MASK, 9'h1FF);
    write_reg(REG_SURVIVE_MASK, 9'h000);
    send_frame9(9'b000_000_000);
    wait_idle();

    // Full-width frame: oversized width saturates, fills both line stores
    write_reg(REG_FRAME_WIDTH, 9'd511);
    write_reg(REG_FRAME_HEIGHT, 9'd3);
    write_reg(REG_BIRTH_MASK, RST_BIRTH_MASK);
    write_reg(REG_SURVIVE_MASK, RST_SURVIVE_MASK);
    run_cells(3 * GRID_MAX, 3);
    wait_idle();

    // Random phases, ending anywhere in a frame before the next setting
    while (cells_sent < 1000) begin
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) val = 9'($urandom_range(0, 2));
        else if (pick < 4) val = 9'($urandom_range(257, 511));
        else if (pick < 5) val = 9'(GRID_MAX);
        else val = 9'($urandom_range(3, 24));
        write_reg(REG_FRAME_WIDTH, val);
      end
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) val = 9'($urandom_range(0, 2));
        else if (pick < 3) val = 9'($urandom_range(256, 511));
        else val = 9'($urandom_range(3, 12));
        write_reg(REG_FRAME_HEIGHT, val);
      end
      if ($urandom_range(0, 1) != 0)
        write_reg(REG_BIRTH_MASK, $urandom_range(0, 1) ? 9'($urandom) : RST_BIRTH_MASK);
      pick = $urandom_range(0, 3);
      if (pick == 0) write_reg(REG_SURVIVE_MASK, 9'($urandom));
      else if (pick == 1) write_reg(REG_SURVIVE_MASK, RST_SURVIVE_MASK | 9'b000010000);
      else if (pick == 2) write_reg(REG_SURVIVE_MASK, RST_SURVIVE_MASK);
      quiet = ($urandom_range(0, 3) == 0);
      run_cells($urandom_range(10, 150), $urandom_range(1, 7));
      wait_idle();
    end

    // Full-height frame, narrowest width, reaches every row position
    quiet = 1'b0;
    write_reg(REG_FRAME_WIDTH, 9'd2);
    write_reg(REG_FRAME_HEIGHT, 9'd300);
    write_reg(REG_BIRTH_MASK, RST_BIRTH_MASK);
    run_cells(3 * GRID_MAX, 4);
    wait_idle();
    repeat (8) @(negedge clk);

    if (board.mismatches == 0 && board.due_cells.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Give up well past the slowest correct run
  initial begin
    #12_000_000;
    $display("timeout with %0d words outstanding", board.due_cells.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
